[rtl/salru_pkg.sv]
// shared types and constants of the lru tag store
`timescale 1ns / 1ps
`default_nettype none
package salru_pkg;
  localparam int MAX_SETS  = 1024;
  localparam int MAX_WAYS  = 8;
  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_W     = 3;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int RANK_W    = 3;
  localparam int TAG_W     = 32;
  localparam int ADDR_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CIDX_W    = 2;
  localparam int CNT_W     = 32;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SET_BITS    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WAYS_USED   = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_RST = 4'd6;
  localparam logic [CFG_W-1:0] SETB_RST   = 4'd7;
  localparam logic [CFG_W-1:0] WAYS_RST   = 4'd8;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
  } res_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;
endpackage
`default_nettype wire

[rtl/salru_if.sv]
// handshake channels of the lru tag store
`timescale 1ns / 1ps
`default_nettype none
interface salru_req_if;
  logic                      valid;
  logic                      ready;
  logic [salru_pkg::ADDR_W-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface salru_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [salru_pkg::WAY_W-1:0] way;
  logic                        evicted;
  logic [salru_pkg::CNT_W-1:0] hit_count;
  modport source (output valid, output hit, output way, output evicted, output hit_count,
                  input ready);
  modport sink (input valid, input hit, input way, input evicted, input hit_count,
                output ready);
endinterface

interface salru_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [salru_pkg::CIDX_W-1:0] index;
  logic [salru_pkg::CFG_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/salru_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/salru_update.sv]
// hit search, victim choice and rank update of one set row
`timescale 1ns / 1ps
`default_nettype none
module salru_update (
  input  salru_pkg::row_t              row,
  input  wire logic [salru_pkg::TAG_W-1:0]  tag,
  input  wire logic [salru_pkg::WCNT_W-1:0] nways,
  output salru_pkg::row_t              row_new,
  output salru_pkg::res_t              res
);
  import salru_pkg::*;

  logic              hit;
  logic [WCNT_W-1:0] hit_way;
  logic              empty;
  logic [WCNT_W-1:0] empty_way;
  logic [WCNT_W-1:0] lru_way;
  logic [WCNT_W-1:0] chosen;
  logic [RANK_W-1:0] hit_rank;

  // lowest matching way and lowest empty way
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    empty     = 1'b0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WCNT_W'(w) < nways) begin
        if (row[w].valid && row[w].tag == tag) begin
          hit     = 1'b1;
          hit_way = WCNT_W'(w);
        end
        if (!row[w].valid) begin
          empty     = 1'b1;
          empty_way = WCNT_W'(w);
        end
      end
    end
  end

  // oldest way, ties to the lowest
  always_comb begin
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < nways && row[w].rank > row[lru_way[WAY_W-1:0]].rank) begin
        lru_way = WCNT_W'(w);
      end
    end
  end

  assign chosen   = hit ? hit_way : (empty ? empty_way : lru_way);
  assign hit_rank = row[hit_way[WAY_W-1:0]].rank;

  // rank aging and line install
  always_comb begin
    row_new = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WCNT_W'(w) < nways && row[w].valid) begin
        if (!hit || row[w].rank < hit_rank) begin
          row_new[w].rank = row[w].rank + RANK_W'(1);
        end
      end
    end
    row_new[chosen[WAY_W-1:0]].rank  = '0;
    row_new[chosen[WAY_W-1:0]].valid = 1'b1;
    row_new[chosen[WAY_W-1:0]].tag   = tag;
  end

  assign res.hit     = hit;
  assign res.way     = chosen[WAY_W-1:0];
  assign res.evicted = !hit && !empty;
endmodule
`default_nettype wire

[rtl/set_assoc_cache_lru_tags.sv]
// top level of the set-associative tag store with true lru
//
//  channel  role    payload
//  req      sink    address
//  rsp      source  hit, way, evicted, hit_count
//  cfg      sink    index, data (always ready)
//
// an access reads the set row from the ram into its registered read port,
// then compares, updates the ranks and writes the row back in the lookup state.
// after reset a clearing pass zeroes every one of the 1024 rows; req is
// not ready during it. a result waits in the output register; a full
// output register holds the lookup until rsp takes its transfer.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_tags (
  input wire logic clk,
  input wire logic rst,
  salru_req_if.sink   req,
  salru_rsp_if.source rsp,
  salru_cfg_if.sink   cfg
);
  import salru_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0]  offset_bits;
  logic [CFG_W-1:0]  set_bits;
  logic [CFG_W-1:0]  ways_used;
  logic [SET_W:0]    clr_cnt;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  logic [WCNT_W-1:0] nways_q;
  logic [CNT_W-1:0]  hits;

  logic              accept;
  logic              done;
  logic [TAG_W-1:0]  tag_in;
  logic [ADDR_W-1:0] set_full;
  logic [WCNT_W-1:0] nways_in;
  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr;
  row_t              row_rd;
  row_t              row_new;
  row_t              ram_wdata;
  res_t              res;

  // configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_RST;
      set_bits    <= SETB_RST;
      ways_used   <= WAYS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OFFSET_BITS: offset_bits <= cfg.data;
        REG_SET_BITS:    set_bits    <= cfg.data;
        REG_WAYS_USED:   ways_used   <= cfg.data;
        default: ;
      endcase
    end
  end

  // address split
  assign tag_in   = req.address >> ({1'b0, offset_bits} + {1'b0, set_bits});
  assign set_full = (req.address >> offset_bits) & ((ADDR_W'(1) << set_bits) - ADDR_W'(1));
  always_comb begin
    if (ways_used == '0) begin
      nways_in = WCNT_W'(1);
    end else if (ways_used > CFG_W'(MAX_WAYS)) begin
      nways_in = WCNT_W'(MAX_WAYS);
    end else begin
      nways_in = ways_used[WCNT_W-1:0];
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign done      = (state == ST_LOOKUP) && (!rsp.valid || rsp.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == (SET_W+1)'(MAX_SETS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: if (done) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + (SET_W+1)'(1);
      end
    end
  end

  // access capture
  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q   <= tag_in;
      set_q   <= set_full[SET_W-1:0];
      nways_q <= nways_in;
    end
  end

  // ram write control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = row_new;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt[SET_W-1:0];
        ram_wdata = '0;
      end
      ST_LOOKUP: ram_we = done;
      default: ;
    endcase
  end

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (set_full[SET_W-1:0]),
    .rdata (row_rd)
  );

  salru_update u_update (
    .row     (row_rd),
    .tag     (tag_q),
    .nways   (nways_q),
    .row_new (row_new),
    .res     (res)
  );

  // output register and hit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      hits      <= '0;
    end else begin
      if (done) begin
        rsp.valid <= 1'b1;
        hits      <= hits + CNT_W'(res.hit);
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.hit       <= res.hit;
      rsp.way       <= res.way;
      rsp.evicted   <= res.evicted;
      rsp.hit_count <= hits + CNT_W'(res.hit);
    end
  end
endmodule
`default_nettype wire

[tb/set_assoc_cache_lru_tags_tb.sv]
// testbench of the lru tag store: predicts each lookup and checks every result transfer
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_lru_tags_tb;
  import salru_pkg::*;

  // register index past the last one, written to check it is ignored
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evicted;
    logic [CNT_W-1:0] hit_count;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic failed = 1'b0;

  salru_req_if req ();
  salru_rsp_if rsp ();
  salru_cfg_if cfg ();

  set_assoc_cache_lru_tags uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always #5 clk = ~clk;

  // predictor copy of the tag store
  logic [TAG_W-1:0]  p_tag   [MAX_SETS*MAX_WAYS];
  logic              p_valid [MAX_SETS*MAX_WAYS];
  logic [RANK_W-1:0] p_rank  [MAX_SETS*MAX_WAYS];
  logic [CNT_W-1:0]  p_hits;
  logic [CFG_W-1:0]  p_offset, p_setb, p_ways;

  logic [ADDR_W-1:0] addr_q [$];
  lookup_t           expected_q [$];
  bit                driving_done = 0;

  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] a);
    int unsigned nw, si, base, ch, w, sh;
    logic [TAG_W-1:0] tg;
    logic [RANK_W-1:0] r;
    bit h, fe;
    lookup_t res;
    nw = p_ways;
    if (nw == 0) nw = 1;
    if (nw > MAX_WAYS) nw = MAX_WAYS;
    sh = int'(p_offset) + int'(p_setb);
    si = ((a >> p_offset) & ((32'd1 << p_setb) - 1)) % MAX_SETS;
    tg = (sh >= 32) ? '0 : (a >> sh);
    base = si * MAX_WAYS;
    h = 0; fe = 0; ch = 0;
    for (w = 0; w < nw; w++)
      if (!h && p_valid[base+w] && p_tag[base+w] == tg) begin
        h = 1; ch = w;
      end
    res = '0;
    if (h) begin
      r = p_rank[base+ch];
      p_hits++;
      for (w = 0; w < nw; w++)
        if (p_valid[base+w] && p_rank[base+w] < r) p_rank[base+w] = p_rank[base+w] + 1;
      p_rank[base+ch] = 0;
    end else begin
      for (w = 0; w < nw; w++)
        if (!fe && !p_valid[base+w]) begin
          fe = 1; ch = w;
        end
      if (!fe) begin
        ch = 0;
        for (w = 1; w < nw; w++)
          if (p_rank[base+w] > p_rank[base+ch]) ch = w;
        res.evicted = 1'b1;
      end
      for (w = 0; w < nw; w++)
        if (p_valid[base+w]) p_rank[base+w] = p_rank[base+w] + 1;
      p_tag[base+ch] = tg;
      p_valid[base+ch] = 1'b1;
      p_rank[base+ch] = 0;
    end
    res.hit = h;
    res.way = ch[WAY_W-1:0];
    res.hit_count = p_hits;
    return res;
  endfunction

  // request driver fed from the pending address queue
  int req_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      expected_q.insert(expected_q.size(), predict_lookup(req.address));
      req_gap = $urandom_range(0, 8);
      if (req_gap == 0 && addr_q.size() > 0) begin
        req.address <= addr_q.pop_front();
      end else begin
        req.valid <= 1'b0;
      end
    end else if (!req.valid) begin
      if (req_gap > 0) req_gap--;
      else if (addr_q.size() > 0) begin
        req.valid <= 1'b1;
        req.address <= addr_q.pop_front();
      end
    end
  end

  // result monitor with random stalls
  int rsp_gap = 0;
  lookup_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.hit, rsp.way, rsp.evicted, rsp.hit_count};
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer");
          failed = 1'b1;
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit exp %0d got %0d", want.hit, got.hit); failed = 1'b1;
          end
          if (got.way !== want.way) begin
            $error("way exp %0d got %0d", want.way, got.way); failed = 1'b1;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted exp %0d got %0d", want.evicted, got.evicted); failed = 1'b1;
          end
          if (got.hit_count !== want.hit_count) begin
            $error("hit_count exp %0d got %0d", want.hit_count, got.hit_count);
            failed = 1'b1;
          end
        end
        rsp_gap = $urandom_range(0, 8);
        if (($urandom_range(0, 3) == 0)) rsp_gap = 0;
      end
      if (rsp_gap > 0) begin
        rsp_gap--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_OFFSET_BITS: p_offset = val;
      REG_SET_BITS:    p_setb = val;
      REG_WAYS_USED:   p_ways = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic queue_addr(input logic [ADDR_W-1:0] a);
    addr_q.insert(addr_q.size(), a);
  endtask

  task automatic wait_drained();
    while (addr_q.size() > 0 || req.valid || expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random address hitting a few sets and tags so hits and evictions are common
  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] a;
    int unsigned sh;
    if ($urandom_range(0, 9) == 0) return $urandom();
    sh = p_offset;
    a = $urandom_range(0, 3) << sh;
    sh = sh + p_setb;
    if (sh < 32) a = a | ($urandom_range(0, 11) << sh);
    return a | ($urandom() & ((32'd1 << p_offset) - 1));
  endfunction

  task automatic random_phase(input int n);
    repeat (n) queue_addr(rand_addr());
    wait_drained();
  endtask

  initial begin
    req.valid = 1'b0;
    req.address = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    p_offset = OFFSET_RST;
    p_setb = SETB_RST;
    p_ways = WAYS_RST;
    p_hits = '0;
    for (int i = 0; i < MAX_SETS*MAX_WAYS; i++) begin
      p_valid[i] = 1'b0;
      p_rank[i] = '0;
      p_tag[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, fills, hits and lru replacement in set 0
    queue_addr(32'h0000_0000);
    queue_addr(32'hFFFF_FFFF);
    queue_addr(32'h0000_0000);
    for (int t = 1; t <= 9; t++) queue_addr(ADDR_W'(t << 13));
    queue_addr(32'h0000_2000);
    queue_addr(32'h0000_0000);
    queue_addr(32'h0001_4000);
    queue_addr(32'hFFFF_FFC0);
    queue_addr(32'hAAAA_AAAA);
    queue_addr(32'h5555_5555);
    wait_drained();

    random_phase(80);
    // zero ways, zero offset and set bits: whole address is the tag
    write_reg(REG_WAYS_USED, 4'd0);
    write_reg(REG_OFFSET_BITS, 4'd0);
    write_reg(REG_SET_BITS, 4'd0);
    random_phase(50);
    // saturating ways, layout using the full set index (tag shift 22, set index 10 bits)
    write_reg(REG_WAYS_USED, 4'd15);
    write_reg(REG_OFFSET_BITS, 4'd12);
    write_reg(REG_SET_BITS, 4'd10);
    random_phase(80);
    write_reg(REG_WAYS_USED, 4'd2);
    write_reg(REG_OFFSET_BITS, 4'd4);
    write_reg(REG_SET_BITS, 4'd2);
    random_phase(80);
    write_reg(REG_UNUSED, 4'd9);
    write_reg(REG_WAYS_USED, 4'd5);
    write_reg(REG_SET_BITS, 4'd15);
    write_reg(REG_OFFSET_BITS, 4'd15);
    random_phase(40);
    write_reg(REG_WAYS_USED, 4'd8);
    write_reg(REG_OFFSET_BITS, 4'd6);
    write_reg(REG_SET_BITS, 4'd1);
    random_phase(100);

    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
